>>> hw/rtl/mscp_pkg.sv
// ----------------------------------------------------------------------------
// mscp_pkg
// Shared types, constants and the marching-squares shape table.
// ----------------------------------------------------------------------------
`default_nettype none

package mscp_pkg;

    // Vertex count ceiling per cell and depth of the front/back queue
    localparam int MAX_VERTS   = 6;
    localparam int QUEUE_DEPTH = 2;

    // Position code of a vertex along one plane axis
    typedef enum logic [1:0] {
        POS_Z = 2'd0,   // cell edge at fraction 0
        POS_H = 2'd1,   // midpoint, moved by occupancy
        POS_O = 2'd2    // cell edge at fraction 1
    } pos_code_t;

    typedef struct packed {
        pos_code_t xc;
        pos_code_t yc;
    } vtx_code_t;

    typedef logic [3:0] case_code_t;
    typedef logic [2:0] vert_idx_t;

    // Front classification status
    typedef struct packed {
        case_code_t code;
        logic       has_shape;
    } cls_t;

    function automatic vtx_code_t vx(pos_code_t a, pos_code_t b);
        vtx_code_t v;
        v.xc = a;
        v.yc = b;
        return v;
    endfunction

    // Number of polygon vertices for each case
    function automatic vert_idx_t shape_count(case_code_t code);
        vert_idx_t n;
        case (code)
            4'd0:                           n = 3'd0;
            4'd1, 4'd2, 4'd4, 4'd8:         n = 3'd3;
            4'd3, 4'd5, 4'd10, 4'd12, 4'd15: n = 3'd4;
            4'd7, 4'd11, 4'd13, 4'd14:      n = 3'd5;
            4'd6, 4'd9:                     n = 3'd6;
            default:                        n = 3'd0;
        endcase
        return n;
    endfunction

    // Vertex position codes of each case's outline, in emission order
    function automatic vtx_code_t shape_vertex(case_code_t code, vert_idx_t idx);
        vtx_code_t row [MAX_VERTS];
        vtx_code_t zz;
        zz  = vx(POS_Z, POS_Z);
        row = '{default: zz};
        case (code)
            4'd1:  row = '{zz, vx(POS_Z, POS_H), vx(POS_H, POS_Z), zz, zz, zz};
            4'd2:  row = '{vx(POS_H, POS_Z), vx(POS_O, POS_H), vx(POS_O, POS_Z),
                           zz, zz, zz};
            4'd3:  row = '{zz, vx(POS_Z, POS_H), vx(POS_O, POS_H), vx(POS_O, POS_Z),
                           zz, zz};
            4'd4:  row = '{vx(POS_Z, POS_O), vx(POS_H, POS_O), vx(POS_Z, POS_H),
                           zz, zz, zz};
            4'd5:  row = '{zz, vx(POS_Z, POS_O), vx(POS_H, POS_O), vx(POS_H, POS_Z),
                           zz, zz};
            4'd6:  row = '{vx(POS_Z, POS_O), vx(POS_H, POS_O), vx(POS_O, POS_H),
                           vx(POS_O, POS_Z), vx(POS_H, POS_Z), vx(POS_Z, POS_H)};
            4'd7:  row = '{zz, vx(POS_Z, POS_O), vx(POS_H, POS_O), vx(POS_O, POS_H),
                           vx(POS_O, POS_Z), zz};
            4'd8:  row = '{vx(POS_O, POS_O), vx(POS_O, POS_H), vx(POS_H, POS_O),
                           zz, zz, zz};
            4'd9:  row = '{zz, vx(POS_Z, POS_H), vx(POS_H, POS_O), vx(POS_O, POS_O),
                           vx(POS_O, POS_H), vx(POS_H, POS_Z)};
            4'd10: row = '{vx(POS_H, POS_Z), vx(POS_H, POS_O), vx(POS_O, POS_O),
                           vx(POS_O, POS_Z), zz, zz};
            4'd11: row = '{zz, vx(POS_Z, POS_H), vx(POS_H, POS_O), vx(POS_O, POS_O),
                           vx(POS_O, POS_Z), zz};
            4'd12: row = '{vx(POS_Z, POS_H), vx(POS_Z, POS_O), vx(POS_O, POS_O),
                           vx(POS_O, POS_H), zz, zz};
            4'd13: row = '{zz, vx(POS_Z, POS_O), vx(POS_O, POS_O), vx(POS_O, POS_H),
                           vx(POS_H, POS_Z), zz};
            4'd14: row = '{vx(POS_Z, POS_H), vx(POS_Z, POS_O), vx(POS_O, POS_O),
                           vx(POS_O, POS_Z), vx(POS_H, POS_Z), zz};
            4'd15: row = '{zz, vx(POS_Z, POS_O), vx(POS_O, POS_O), vx(POS_O, POS_Z),
                           zz, zz};
            default: row = '{default: zz};
        endcase
        return (idx < 3'(MAX_VERTS)) ? row[idx] : zz;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mscp_front.sv
// ----------------------------------------------------------------------------
// mscp_front
// Accepts cells, forms the corner case and the scaled corner fractions, and
// writes non-empty cells into the work queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mscp_front
    import mscp_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 8
)
(
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [8:0]                    occ_corner0,
    input  wire logic [8:0]                    occ_corner1,
    input  wire logic [8:0]                    occ_corner2,
    input  wire logic [8:0]                    occ_corner3,
    input  wire logic signed [COORD_WIDTH-1:0] cell_x,
    input  wire logic signed [COORD_WIDTH-1:0] cell_y,
    input  wire logic signed [COORD_WIDTH-1:0] cell_z,
    input  wire logic                          q_full,
    output logic                               q_wr,
    output logic [4+4*(FRAC_BITS+1)+3*COORD_WIDTH-1:0] q_wdata
);

    localparam int FW   = FRAC_BITS + 1;
    localparam int SH_L = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
    localparam int SH_R = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
    localparam int WW   = 9 + SH_L;
    localparam logic [8:0] OCC_ONE = 9'd256;

    logic [8:0]    occ   [4];
    logic [8:0]    sat   [4];
    logic [WW-1:0] wide  [4];
    logic [FW-1:0] frac  [4];
    cls_t          cls;

    assign occ[0] = occ_corner0;
    assign occ[1] = occ_corner1;
    assign occ[2] = occ_corner2;
    assign occ[3] = occ_corner3;

    // Saturate to 1.0 and rescale to the vertex fraction width
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sat[i]  = (occ[i] > OCC_ONE) ? OCC_ONE : occ[i];
            wide[i] = WW'(sat[i]) << SH_L;
            frac[i] = FW'(wide[i] >> SH_R);
        end
    end

    // Corner case from the raw occupancies
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            cls.code[i] = (occ[i] != 9'd0);
        end
        cls.has_shape = (shape_count(cls.code) != 3'd0);
    end

    // Empty cells are consumed here and never reach the queue
    assign full    = q_full;
    assign q_wr    = push && !q_full && cls.has_shape;
    assign q_wdata = {cls.code, frac[3], frac[2], frac[1], frac[0],
                      cell_z, cell_y, cell_x};

endmodule

`default_nettype wire

>>> hw/rtl/mscp_queue.sv
// ----------------------------------------------------------------------------
// mscp_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mscp_queue
    import mscp_pkg::*;
#(
    parameter int WIDTH = 88
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  q_full,
    input  wire logic             rd,
    output logic                  q_empty,
    output logic [WIDTH-1:0]      rdata
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_wr, do_rd;

    assign q_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/mscp_back.sv
// ----------------------------------------------------------------------------
// mscp_back
// Walks the shape of the queue head one vertex per cycle while the result
// register is free or popped, loading each vertex into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mscp_back
    import mscp_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 8
)
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    q_empty,
    input  wire logic [4+4*(FRAC_BITS+1)+3*COORD_WIDTH-1:0] q_rdata,
    output logic                                         q_rd,
    output logic                                         empty,
    input  wire logic                                    pop,
    output logic signed [COORD_WIDTH+FRAC_BITS:0]        vert_x,
    output logic signed [COORD_WIDTH+FRAC_BITS:0]        vert_y,
    output logic signed [COORD_WIDTH-1:0]                vert_z,
    output logic [3:0]                                   case_code,
    output logic [2:0]                                   vert_number,
    output logic                                         last_vertex
);

    localparam int FW = FRAC_BITS + 1;
    localparam int PW = COORD_WIDTH + FRAC_BITS + 1;
    localparam logic [FW-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Queue head fields
    logic [COORD_WIDTH-1:0] h_cx, h_cy, h_cz;
    logic [FW-1:0]          h_f0, h_f1, h_f2, h_f3;
    case_code_t             h_case;

    assign {h_case, h_f3, h_f2, h_f1, h_f0, h_cz, h_cy, h_cx} = q_rdata;

    // Midpoint along an edge: first corner, else one minus the second
    function automatic logic [FW-1:0] edge_pos(logic [FW-1:0] first,
                                               logic [FW-1:0] second);
        return (first == '0) ? FRAC_ONE - second : first;
    endfunction

    vert_idx_t        idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [PW-1:0]    vert_x_reg, vert_x_next;
    logic [PW-1:0]    vert_y_reg, vert_y_next;
    logic [COORD_WIDTH-1:0] vert_z_reg;
    case_code_t       case_code_reg;
    vert_idx_t        vert_number_reg;
    logic             last_reg, last_next;

    vtx_code_t        vc;
    vert_idx_t        count;
    logic [FW-1:0]    half_x, half_y, fx, fy;
    logic             load, pop_beat;

    assign pop_beat = pop && out_valid_reg;
    assign load     = !q_empty && (!out_valid_reg || pop);

    // Vertex fraction and position
    always_comb
    begin
        vc     = shape_vertex(h_case, idx_reg);
        count  = shape_count(h_case);
        half_x = (vc.yc == POS_Z) ? edge_pos(h_f0, h_f1) : edge_pos(h_f2, h_f3);
        half_y = (vc.xc == POS_Z) ? edge_pos(h_f0, h_f2) : edge_pos(h_f1, h_f3);

        case (vc.xc)
            POS_H:   fx = half_x;
            POS_O:   fx = FRAC_ONE;
            default: fx = '0;
        endcase

        if (vc.yc == POS_H && vc.xc != POS_H)
        begin
            fy = half_y;
        end
        else if (vc.yc == POS_O)
        begin
            fy = FRAC_ONE;
        end
        else
        begin
            fy = '0;
        end

        vert_x_next = {h_cx[COORD_WIDTH-1], h_cx, {FRAC_BITS{1'b0}}}
                    + {{COORD_WIDTH{1'b0}}, fx};
        vert_y_next = {h_cy[COORD_WIDTH-1], h_cy, {FRAC_BITS{1'b0}}}
                    + {{COORD_WIDTH{1'b0}}, fy};
        last_next   = (idx_reg == count - 3'd1);
    end

    // Vertex sequencing and result handshake
    always_comb
    begin
        q_rd           = load && last_next;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = last_next ? 3'd0 : idx_reg + 3'd1;
            out_valid_next = 1'b1;
        end
        else if (pop_beat)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            vert_x_reg      <= vert_x_next;
            vert_y_reg      <= vert_y_next;
            vert_z_reg      <= h_cz;
            case_code_reg   <= h_case;
            vert_number_reg <= idx_reg;
            last_reg        <= last_next;
        end
    end

    assign empty       = !out_valid_reg;
    assign vert_x      = vert_x_reg;
    assign vert_y      = vert_y_reg;
    assign vert_z      = vert_z_reg;
    assign case_code   = case_code_reg;
    assign vert_number = vert_number_reg;
    assign last_vertex = last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/marching_squares_cell_polygon.sv
// ----------------------------------------------------------------------------
// marching_squares_cell_polygon
// Marching-squares cell to outline polygon, one vertex per result beat.
// ----------------------------------------------------------------------------
//  channel  | handshake     | payload
//  ---------+---------------+-----------------------------------------------
//  cell in  | push / full   | occ_corner0..3, cell_x, cell_y, cell_z
//  vert out | pop  / empty  | vert_x, vert_y, vert_z, case_code,
//           |               | vert_number, last_vertex
//
//  A cell takes one beat on the input; an empty-case cell leaves nothing.
//  The back emits a vertex per cycle, 3 to 6 per cell, unless the result
//  register stalls. The first vertex passes the queue, then the result
//  register. A two-entry queue splits front and back; full rises only when
//  both entries are held. A result stall holds the back, and the front once
//  the queue fills. Reset clears queue and result valid; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module marching_squares_cell_polygon
    import mscp_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 8
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic [8:0]                           occ_corner0,
    input  wire logic [8:0]                           occ_corner1,
    input  wire logic [8:0]                           occ_corner2,
    input  wire logic [8:0]                           occ_corner3,
    input  wire logic signed [COORD_WIDTH-1:0]        cell_x,
    input  wire logic signed [COORD_WIDTH-1:0]        cell_y,
    input  wire logic signed [COORD_WIDTH-1:0]        cell_z,
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic signed [COORD_WIDTH+FRAC_BITS:0]     vert_x,
    output logic signed [COORD_WIDTH+FRAC_BITS:0]     vert_y,
    output logic signed [COORD_WIDTH-1:0]             vert_z,
    output logic [3:0]                                case_code,
    output logic [2:0]                                vert_number,
    output logic                                      last_vertex
);

    localparam int EW = 4 + 4 * (FRAC_BITS + 1) + 3 * COORD_WIDTH;

    logic          q_wr, q_rd, q_full, q_empty;
    logic [EW-1:0] q_wdata, q_rdata;

    // Front: classify and enqueue
    mscp_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .push        (push),
        .full        (full),
        .occ_corner0 (occ_corner0),
        .occ_corner1 (occ_corner1),
        .occ_corner2 (occ_corner2),
        .occ_corner3 (occ_corner3),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .cell_z      (cell_z),
        .q_full      (q_full),
        .q_wr        (q_wr),
        .q_wdata     (q_wdata)
    );

    // Work queue
    mscp_queue #(
        .WIDTH (EW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wdata   (q_wdata),
        .q_full  (q_full),
        .rd      (q_rd),
        .q_empty (q_empty),
        .rdata   (q_rdata)
    );

    // Back: vertex walk and result register
    mscp_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_rdata     (q_rdata),
        .q_rd        (q_rd),
        .empty       (empty),
        .pop         (pop),
        .vert_x      (vert_x),
        .vert_y      (vert_y),
        .vert_z      (vert_z),
        .case_code   (case_code),
        .vert_number (vert_number),
        .last_vertex (last_vertex)
    );

endmodule

`default_nettype wire
